@@ sv/ntu_pkg.sv @@
package ntu_pkg;

	localparam logic [1:0] ST_HIT  = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] REG_OWN_X = 2'd0;
	localparam logic [1:0] REG_OWN_Y = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam int unsigned SQ_W   = 34;
	localparam int unsigned ROOT_W = 17;
	localparam int unsigned SQRT_STEPS = 17;

	typedef struct packed {
		logic [15:0]        node_id;
		logic signed [31:0] seq_number;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  entry_index;
		logic [15:0] times_seen;
		logic [15:0] in_range_packets;
		logic [16:0] distance;
		logic [15:0] farthest_id;
		logic        farthest_valid;
	} result_t;

	// Data handed from one cell to the next along the table.
	typedef struct packed {
		logic        hit;
		logic        wr;
		logic        ins;
		logic        in_range;
		logic [15:0] id;
		logic [15:0] px;
		logic [15:0] py;
		logic [16:0] root_dist;
	} link_t;

	// What the hitting cell reports back.
	typedef struct packed {
		logic        hit;
		logic [15:0] seen;
		logic [15:0] inr;
		logic [16:0] slot_dist;
	} hit_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

@@ sv/ntu_cell.sv @@
module ntu_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           own_ins,
	input  ntu_pkg::link_t link_in,
	output ntu_pkg::link_t link_out,
	output ntu_pkg::hit_t  hit_out
);

	logic        valid_q;
	logic [15:0] id_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [16:0] dist_q;
	logic [15:0] seen_q;
	logic [15:0] inr_q;
	logic        match;

	// A cell matches only if no lower cell has already claimed the id.
	assign match = valid_q && (id_q == link_in.id) && !link_in.hit;

	always_comb begin
		link_out = link_in;
		link_out.hit = link_in.hit | match;
		hit_out.hit  = match;
		hit_out.seen = ntu_pkg::sat_inc(seen_q);
		hit_out.inr  = (link_in.in_range) ? ntu_pkg::sat_inc(inr_q) : inr_q;
		hit_out.slot_dist = dist_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (link_in.ins && own_ins) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.ins && own_ins) begin
			id_q   <= link_in.id;
			x_q    <= link_in.px;
			y_q    <= link_in.py;
			dist_q <= link_in.root_dist;
			seen_q <= 16'd1;
			inr_q  <= {15'd0, link_in.in_range};
		end else if (link_in.wr && match) begin
			x_q    <= link_in.px;
			y_q    <= link_in.py;
			seen_q <= hit_out.seen;
			inr_q  <= hit_out.inr;
		end
	end

endmodule

@@ sv/ntu_sqrt.sv @@
module ntu_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [ntu_pkg::SQ_W-1:0]      radicand,
	output logic                          done,
	output logic [ntu_pkg::ROOT_W-1:0]    root
);

	logic [ntu_pkg::SQ_W-1:0]   rem_q;
	logic [ntu_pkg::ROOT_W-1:0] root_q;
	logic [ntu_pkg::SQ_W-1:0]   rad_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic [ntu_pkg::SQ_W+1:0]   trial;
	logic [ntu_pkg::SQ_W+1:0]   shifted;

	// Restoring root, two radicand bits per step, most significant first.
	always_comb begin
		shifted = {rem_q, rad_q[ntu_pkg::SQ_W-1 -: 2]};
		trial   = shifted - {{(ntu_pkg::SQ_W-ntu_pkg::ROOT_W){1'b0}}, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(ntu_pkg::SQRT_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= radicand;
		end else if (busy_q) begin
			rad_q <= {rad_q[ntu_pkg::SQ_W-3:0], 2'b00};
			if (!trial[ntu_pkg::SQ_W+1]) begin
				rem_q  <= trial[ntu_pkg::SQ_W-1:0];
				root_q <= {root_q[ntu_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[ntu_pkg::SQ_W-1:0];
				root_q <= {root_q[ntu_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;

endmodule

@@ sv/neighbor_table_update_unit.sv @@
// A report that hits an existing entry yields its result word straight from the lookup.
// A new entry needs the squared distance (registered) and an iterative square root of 17
// steps before an insert yields its word; a drop when full yields it from the lookup too.
// One report is in flight at a time: busy falls in the cycle its word is shown, so the
// next report can be taken in that same cycle.
// The receiver cannot stall; each result word is shown for one cycle on result_valid.
// Reset is asynchronous, active low, and empties the table and the farthest record.
module neighbor_table_update_unit #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ntu_pkg::item_t    item,
	output logic              result_valid,
	output ntu_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_SQ   = 4'b0100,
		S_ROOT = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [15:0] own_x_q;
	logic signed [15:0] own_y_q;
	logic [15:0]        limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q <= '0;
			own_y_q <= '0;
			limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ntu_pkg::REG_OWN_X: own_x_q <= cfg_data;
				ntu_pkg::REG_OWN_Y: own_y_q <= cfg_data;
				ntu_pkg::REG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The accepted report is held here for the whole of its processing.
	ntu_pkg::item_t item_q;
	logic           in_range_q;
	logic [CNT_W-1:0] fill_q;
	logic [ntu_pkg::SQ_W-1:0] max_sq_q;
	logic [15:0]    max_owner_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Chain of cells: the search word ripples through; only in S_LOOK does a hit
	// write, and only at the end of the root does the insert write.
	ntu_pkg::link_t chain [TABLE_DEPTH+1];
	ntu_pkg::hit_t  hits  [TABLE_DEPTH];
	logic [16:0]    root;
	logic           root_done;

	always_comb begin
		chain[0].hit       = 1'b0;
		chain[0].wr        = (state_q == S_LOOK);
		chain[0].ins       = root_done;
		chain[0].in_range  = in_range_q;
		chain[0].id        = item_q.node_id;
		chain[0].px        = item_q.pos_x;
		chain[0].py        = item_q.pos_y;
		chain[0].root_dist = root;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		ntu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.own_ins  (fill_q == CNT_W'(g)),
			.link_in  (chain[g]),
			.link_out (chain[g+1]),
			.hit_out  (hits[g])
		);
	end

	// Pick the single hitting cell's report (at most one matches).
	ntu_pkg::hit_t hit_sel;
	logic [IDX_W-1:0] hit_idx;
	always_comb begin
		hit_sel = '0;
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hits[i].hit) begin
				hit_sel = hits[i];
				hit_idx = IDX_W'(i);
			end
		end
	end

	// Squared distance, registered before the root unit.
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [16:0]        adx;
	logic [16:0]        ady;
	logic [ntu_pkg::SQ_W-1:0] sq_x;
	logic [ntu_pkg::SQ_W-1:0] sq_y;
	logic [ntu_pkg::SQ_W-1:0] d2_q;
	logic sq_go;

	always_comb begin
		dx   = 17'(item_q.pos_x) - 17'(own_x_q);
		dy   = 17'(item_q.pos_y) - 17'(own_y_q);
		adx  = dx[16] ? 17'(-dx) : dx;
		ady  = dy[16] ? 17'(-dy) : dy;
		sq_x = adx * adx;
		sq_y = ady * ady;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) begin
			d2_q <= sq_x + sq_y;
		end
	end

	assign sq_go = (state_q == S_SQ);

	ntu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go),
		.radicand (d2_q),
		.done     (root_done),
		.root     (root)
	);

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			max_sq_q     <= '0;
			max_owner_q  <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_LOOK;
				end
				S_LOOK: begin
					if (hit_sel.hit || fill_q == CNT_W'(TABLE_DEPTH)) begin
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_ROOT;
				S_ROOT: begin
					if (root_done) begin
						result_valid <= 1'b1;
						fill_q       <= fill_q + CNT_W'(1);
						if (d2_q > max_sq_q) begin
							max_sq_q    <= d2_q;
							max_owner_q <= item_q.node_id;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= item;
			in_range_q <= !item.seq_number[31] && (item.seq_number[30:0] < 31'(limit_q));
		end
	end

	// Result payload, built on the cycle that completes each report.
	logic [1:0]  res_status;
	logic [4:0]  res_index;
	logic [15:0] res_seen;
	logic [15:0] res_inr;
	logic [16:0] res_dist;
	logic        ins_new_max;
	logic [IDX_W:0] fill_ext;

	always_comb begin
		fill_ext    = (IDX_W+1)'(fill_q);
		ins_new_max = root_done && (d2_q > max_sq_q);
		res_status  = ntu_pkg::ST_FULL;
		res_index   = '0;
		res_seen    = '0;
		res_inr     = '0;
		res_dist    = '0;
		if (state_q == S_ROOT) begin
			res_status = ntu_pkg::ST_INS;
			res_index  = 5'(fill_ext);
			res_seen   = 16'd1;
			res_inr    = {15'd0, in_range_q};
			res_dist   = root;
		end else if (hit_sel.hit) begin
			res_status = ntu_pkg::ST_HIT;
			res_index  = 5'({1'b0, hit_idx});
			res_seen   = hit_sel.seen;
			res_inr    = hit_sel.inr;
			res_dist   = hit_sel.slot_dist;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_LOOK) || root_done) begin
			result.status           <= res_status;
			result.entry_index      <= res_index;
			result.times_seen       <= res_seen;
			result.in_range_packets <= res_inr;
			result.distance         <= res_dist;
			result.farthest_id      <= ins_new_max ? item_q.node_id : max_owner_q;
			result.farthest_valid   <= ins_new_max || (max_sq_q != '0);
		end
	end

`ifndef SYNTHESIS
	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> state_q == S_IDLE)
		else $error("result shown while still busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond depth");
	a_root_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == S_ROOT)
		else $error("root finished outside insert");
	a_max_grows: assert property (@(posedge clk) disable iff (!arst_n)
		max_sq_q >= $past(max_sq_q))
		else $error("farthest distance shrank");
`endif

endmodule

@@ tb/tb_neighbor_table_update_unit.sv @@
module tb_neighbor_table_update_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 32;
	localparam int WATCHDOG = 20000;
	localparam int RANDOM_WORDS = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ntu_pkg::item_t item = '0;
	logic result_valid;
	ntu_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	neighbor_table_update_unit #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// The testbench's own copy of the neighbour table and its settings.
	logic        nb_valid [DEPTH];
	logic [15:0] nb_id [DEPTH];
	logic [16:0] nb_dist [DEPTH];
	logic [15:0] nb_seen [DEPTH];
	logic [15:0] nb_inr [DEPTH];
	int          nb_fill;
	logic [33:0] far_sq;
	logic [15:0] far_owner;
	logic signed [15:0] my_x, my_y;
	logic [15:0] seq_limit;

	ntu_pkg::result_t pending_words [$];
	int mismatches = 0;
	int idle_cycles = 0;

	function automatic logic [16:0] floor_root(input logic [33:0] n);
		logic [33:0] lo, hi, mid;
		lo = 0;
		hi = 34'd131071;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		return lo[16:0];
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Applies one report to the table copy and returns the word it should yield.
	function automatic ntu_pkg::result_t update_table(input ntu_pkg::item_t r);
		ntu_pkg::result_t w;
		int slot;
		logic counts;
		logic signed [33:0] dx, dy;
		logic [33:0] d2;
		w = '0;
		slot = -1;
		counts = !r.seq_number[31] && (r.seq_number < $signed({17'd0, seq_limit}));
		for (int i = 0; i < DEPTH; i++)
			if (slot < 0 && nb_valid[i] && nb_id[i] == r.node_id) slot = i;
		if (slot >= 0) begin
			nb_seen[slot] = bump(nb_seen[slot]);
			if (counts) nb_inr[slot] = bump(nb_inr[slot]);
			w.status = ntu_pkg::ST_HIT;
		end else if (nb_fill < DEPTH) begin
			slot = nb_fill;
			dx = 34'(r.pos_x) - 34'(my_x);
			dy = 34'(r.pos_y) - 34'(my_y);
			d2 = $unsigned(dx * dx + dy * dy);
			nb_valid[slot] = 1'b1;
			nb_id[slot] = r.node_id;
			nb_dist[slot] = floor_root(d2);
			nb_seen[slot] = 16'd1;
			nb_inr[slot] = counts ? 16'd1 : 16'd0;
			nb_fill++;
			if (d2 > far_sq) begin
				far_sq = d2;
				far_owner = r.node_id;
			end
			w.status = ntu_pkg::ST_INS;
		end else begin
			w.status = ntu_pkg::ST_FULL;
		end
		if (slot >= 0) begin
			w.entry_index = slot[4:0];
			w.times_seen = nb_seen[slot];
			w.in_range_packets = nb_inr[slot];
			w.distance = nb_dist[slot];
		end
		w.farthest_id = far_owner;
		w.farthest_valid = (far_sq != 0);
		return w;
	endfunction

	task automatic clear_table();
		for (int i = 0; i < DEPTH; i++) nb_valid[i] = 1'b0;
		nb_fill = 0;
		far_sq = '0;
		far_owner = '0;
	endtask

	// Result words are checked at the edge that ends their cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word %p", result);
			end else begin
				ntu_pkg::result_t want;
				want = pending_words.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	// The watchdog counts cycles in which no word moves in either direction.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Watchdog expired");
			$display("** neighbor_table_update_unit: FAILED **");
			$finish;
		end
	end

	task automatic wait_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ntu_pkg::REG_OWN_X: my_x = val;
			ntu_pkg::REG_OWN_Y: my_y = val;
			ntu_pkg::REG_LIMIT: seq_limit = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Sends one report word. A random hold-off precedes it when asked; start
	// stays high from one report to the next when there is no hold-off.
	task automatic send_report(input ntu_pkg::item_t r, input bit gaps);
		int gap;
		gap = gaps ? int'($urandom_range(17)) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			wait_cycles(gap);
		end
		start <= 1'b1;
		item <= r;
		do @(posedge clk); while (busy);
		pending_words.insert(pending_words.size(), update_table(r));
	endtask

	// Waits until every expected word has arrived, then lets any drop settle.
	task automatic drain();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		wait_cycles(25);
	endtask

	function automatic ntu_pkg::item_t make_report(input logic [15:0] id,
			input logic [31:0] sq, input logic [15:0] x, input logic [15:0] y);
		ntu_pkg::item_t r;
		r.node_id = id;
		r.seq_number = sq;
		r.pos_x = x;
		r.pos_y = y;
		return r;
	endfunction

	// Random reports: mostly ids from a small pool so hits are common, with
	// occasional fully random ids and sequence numbers; positions are mostly random, else corners.
	function automatic ntu_pkg::item_t random_report(input int pool);
		ntu_pkg::item_t r;
		r.node_id = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(pool));
		case ($urandom_range(3))
			0: r.seq_number = $urandom;
			1: r.seq_number = $urandom_range(40);
			2: r.seq_number = $urandom_range(32'h7FFFFFFF, 32'h7FFFFFF0);
			default: r.seq_number = -int'($urandom_range(5));
		endcase
		if ($urandom_range(3) == 0) begin
			r.pos_x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
			r.pos_y = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		end else begin
			r.pos_x = 16'($urandom);
			r.pos_y = 16'($urandom);
		end
		return r;
	endfunction

	typedef struct {
		ntu_pkg::item_t   r;
		bit               known;
		ntu_pkg::result_t want;
	} stim_row_t;

	stim_row_t directed [$];

	initial begin
		stim_row_t row;
		clear_table();
		my_x = 0;
		my_y = 0;
		seq_limit = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at reset settings: a report at the own position gives
		// zero distance and leaves the farthest record unset.
		row.known = 1'b1;
		row.r = make_report(16'h0000, 32'd0, 16'h0000, 16'h0000);
		row.want = '{status: ntu_pkg::ST_INS, entry_index: 5'd0, times_seen: 16'd1,
			in_range_packets: 16'd0, distance: 17'd0, farthest_id: 16'd0,
			farthest_valid: 1'b0};
		directed.insert(directed.size(), row);
		// The largest distance, from the opposite corner of the plane.
		row.r = make_report(16'hFFFF, 32'h80000000, 16'h8000, 16'h8000);
		row.want = '{status: ntu_pkg::ST_INS, entry_index: 5'd1, times_seen: 16'd1,
			in_range_packets: 16'd0, distance: 17'd46340, farthest_id: 16'hFFFF,
			farthest_valid: 1'b1};
		directed.insert(directed.size(), row);
		// A hit keeps the stored distance even though the position moved.
		row.r = make_report(16'hFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF);
		row.want = '{status: ntu_pkg::ST_HIT, entry_index: 5'd1, times_seen: 16'd2,
			in_range_packets: 16'd0, distance: 17'd46340, farthest_id: 16'hFFFF,
			farthest_valid: 1'b1};
		directed.insert(directed.size(), row);
		row.known = 1'b0;
		// An equal squared distance does not take over the farthest record.
		row.r = make_report(16'h1234, 32'd5, 16'h8000, 16'h8000);
		directed.insert(directed.size(), row);
		row.r = make_report(16'h00AA, 32'd1, 16'd3, 16'd4);
		directed.insert(directed.size(), row);
		row.r = make_report(16'h00AA, 32'hFFFFFFFF, 16'h0000, 16'h0000);
		directed.insert(directed.size(), row);

		foreach (directed[i]) begin
			send_report(directed[i].r, 1'b0);
			if (directed[i].known && pending_words[$] !== directed[i].want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Directed row %0d: expected %p, table copy gives %p", i,
						directed[i].want, pending_words[$]);
			end
		end
		drain();

		// Far corner as the own position and a working sequence limit; fill the table
		// to overflow, with low ids so later hits land.
		write_reg(ntu_pkg::REG_OWN_X, 16'h7FFF);
		write_reg(ntu_pkg::REG_OWN_Y, 16'h7FFF);
		write_reg(ntu_pkg::REG_LIMIT, 16'd10);
		write_reg(2'd3, 16'hBEEF);
		for (int i = 0; i < 28; i++)
			send_report(make_report(16'(i + 2), 32'(i), 16'h8000 + 16'(i * 7), 16'(i)),
				1'b0);
		send_report(make_report(16'h0BAD, 32'd9, 16'h8000, 16'h8000), 1'b0);
		send_report(make_report(16'h0BAE, 32'd10, 16'h8000, 16'h8000), 1'b0);
		send_report(make_report(16'h0005, 32'd9, 16'h0000, 16'h0000), 1'b0);
		drain();

		// Random phases on a full table, then fresh tables are not possible without
		// reset, so the settings change between phases with the table full.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_reg(ntu_pkg::REG_LIMIT, 16'hFFFF);
				1: write_reg(ntu_pkg::REG_LIMIT, 16'h0000);
				2: begin
					write_reg(ntu_pkg::REG_OWN_X, 16'h8000);
					write_reg(ntu_pkg::REG_OWN_Y, 16'h8000);
					write_reg(ntu_pkg::REG_LIMIT, 16'd20);
				end
				default: begin
					write_reg(ntu_pkg::REG_OWN_X, 16'($urandom));
					write_reg(ntu_pkg::REG_OWN_Y, 16'($urandom));
					write_reg(ntu_pkg::REG_LIMIT, 16'($urandom));
				end
			endcase
			for (int n = 0; n < RANDOM_WORDS / 4; n++)
				send_report(random_report(40), phase != 1);
			drain();
		end

		if (mismatches == 0) $display("** neighbor_table_update_unit: PASSED **");
		else $display("** neighbor_table_update_unit: FAILED **");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/ntu_pkg.sv
sv/ntu_cell.sv
sv/ntu_sqrt.sv
sv/neighbor_table_update_unit.sv
tb/tb_neighbor_table_update_unit.sv
